// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define RMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define RMT_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rmt_pkg
// Operation codes, status codes and shared types of the mutex table.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_LOCK   = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_HELD_OTHER = 3'd2,
        ST_NOT_OWNER  = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_DEPTH_FULL = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] task_id;
        logic [7:0] mtx_id;
        logic [1:0] operation;
    } req_t;

    typedef struct packed {
        logic       is_locked;
        logic [7:0] depth_after;
        logic [6:0] new_id;
        status_t    status;
    } res_t;

    typedef struct packed {
        logic wr_en;
        logic cnt_inc;
    } upd_t;

endpackage

// ===== rtl/rmt_table.sv =====
// ----------------------------------------------------------------------------
// rmt_table
// Entry store of the mutex table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rmt_table #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read before write: a read at the address being written returns the old word.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rmt_exec.sv =====
// ----------------------------------------------------------------------------
// rmt_exec
// Decides one request against its table entry and the created count.
// ----------------------------------------------------------------------------
module rmt_exec #(
    parameter int DEPTH_BITS = 8,
    parameter int SLOT_W     = 3,
    parameter int CNT_W      = 4,
    parameter int SLOTS      = 8
) (
    input  rmt_pkg::req_t         req,
    input  logic [CNT_W-1:0]      count,
    input  logic [7:0]            cur_owner,
    input  logic [DEPTH_BITS-1:0] cur_depth,
    output rmt_pkg::res_t         res,
    output rmt_pkg::upd_t         upd,
    output logic [SLOT_W-1:0]     wr_slot,
    output logic [7:0]            wr_owner,
    output logic [DEPTH_BITS-1:0] wr_depth
);
    import rmt_pkg::*;

    logic [7:0]            id_m1;
    logic                  bad_id;
    logic                  full;
    logic                  cur_locked;
    logic [DEPTH_BITS-1:0] dec_depth;
    logic [DEPTH_BITS-1:0] shown_depth;
    logic [DEPTH_BITS+7:0] shown_ext;

    assign id_m1      = req.mtx_id - 8'd1;
    assign full       = (count == CNT_W'(SLOTS));
    assign bad_id     = (req.mtx_id == 8'd0) || (req.mtx_id > 8'(count));
    // A held mutex always has a non-zero depth, so the flag is not stored.
    assign cur_locked = (cur_depth != '0);
    assign dec_depth  = cur_depth - DEPTH_BITS'(1);

    always_comb begin
        res.status    = ST_OK;
        res.new_id    = 7'd0;
        res.is_locked = 1'b0;
        shown_depth   = '0;
        upd           = '0;
        wr_slot       = id_m1[SLOT_W-1:0];
        wr_owner      = cur_owner;
        wr_depth      = cur_depth;
        unique case (req.operation)
            OP_CREATE: begin
                if (full) begin
                    res.status = ST_TABLE_FULL;
                end else begin
                    res.new_id  = 7'(count) + 7'd1;
                    upd.wr_en   = 1'b1;
                    upd.cnt_inc = 1'b1;
                    wr_slot     = count[SLOT_W-1:0];
                    wr_owner    = 8'd0;
                    wr_depth    = '0;
                end
            end
            OP_LOCK: begin
                if (bad_id) begin
                    res.status = ST_BAD_ID;
                end else if (cur_locked && (cur_owner != req.task_id)) begin
                    res.status    = ST_HELD_OTHER;
                    shown_depth   = cur_depth;
                    res.is_locked = cur_locked;
                end else if (cur_depth == {DEPTH_BITS{1'b1}}) begin
                    res.status    = ST_DEPTH_FULL;
                    shown_depth   = cur_depth;
                    res.is_locked = cur_locked;
                end else begin
                    upd.wr_en     = 1'b1;
                    wr_owner      = req.task_id;
                    wr_depth      = cur_depth + DEPTH_BITS'(1);
                    shown_depth   = wr_depth;
                    res.is_locked = 1'b1;
                end
            end
            OP_UNLOCK: begin
                if (bad_id) begin
                    res.status = ST_BAD_ID;
                end else if (!cur_locked || (cur_owner != req.task_id)) begin
                    res.status    = ST_NOT_OWNER;
                    shown_depth   = cur_depth;
                    res.is_locked = cur_locked;
                end else begin
                    upd.wr_en     = 1'b1;
                    wr_depth      = dec_depth;
                    wr_owner      = (dec_depth == '0) ? 8'd0 : cur_owner;
                    shown_depth   = dec_depth;
                    res.is_locked = (dec_depth != '0);
                end
            end
            default: begin
                res.status = ST_BAD_ID;
            end
        endcase
        shown_ext       = {8'd0, shown_depth};
        res.depth_after = shown_ext[7:0];
    end

endmodule

// ===== rtl/recursive_mutex_table.sv =====
// ----------------------------------------------------------------------------
// recursive_mutex_table
// A request word is registered in the request stage, then its result word in the
// output register. Throughput: one request per cycle while the output is not
// stalled, set by the single read-modify-write of the entry store per cycle.
// Reset clears the created count and the valid flags only; entries need no
// clearing, as a slot is cleared when it is created and never used before.
// ----------------------------------------------------------------------------
module recursive_mutex_table #(
    parameter int MUTEX_SLOTS = 8,
    parameter int DEPTH_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // operation[1:0], mtx_id[9:2], task_id[17:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // status[2:0], new_id[9:3], depth_after[17:10],
                                  // is_locked[18]
);
    import rmt_pkg::*;

    localparam int SLOT_W = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MUTEX_SLOTS + 1);
    localparam int ENT_W  = 8 + DEPTH_BITS;

    req_t                  s_req;
    logic                  accept;
    logic                  a_adv;
    logic                  out_free;
    logic [7:0]            rd_id_m1;
    logic [SLOT_W-1:0]     rd_slot;
    logic [ENT_W-1:0]      rd_data;
    logic [ENT_W-1:0]      cur_entry;
    logic [ENT_W-1:0]      wr_entry;
    logic                  wr_en;
    res_t                  res;
    upd_t                  upd;
    logic [SLOT_W-1:0]     wr_slot;
    logic [7:0]            wr_owner;
    logic [DEPTH_BITS-1:0] wr_depth;

    logic                  a_vld_reg,   a_vld_next;
    req_t                  a_req_reg;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic                  byp_vld_reg;
    logic [ENT_W-1:0]      byp_data_reg;
    logic                  o_vld_reg,   o_vld_next;
    res_t                  o_res_reg;

    assign s_req    = req_t'(s_tdata[17:0]);
    assign out_free = !o_vld_reg || m_tready;
    assign a_adv    = a_vld_reg && out_free;
    assign s_tready = aresetn && (!a_vld_reg || a_adv);
    assign accept   = s_tvalid && s_tready;
    assign rd_id_m1 = s_req.mtx_id - 8'd1;
    assign rd_slot  = rd_id_m1[SLOT_W-1:0];
    assign wr_en    = a_adv && upd.wr_en;
    assign wr_entry = {wr_owner, wr_depth};

    // An entry written on the same edge as the read is taken from the bypass.
    assign cur_entry = byp_vld_reg ? byp_data_reg : rd_data;

    rmt_table #(
        .DEPTH  (MUTEX_SLOTS),
        .ADDR_W (SLOT_W),
        .DATA_W (ENT_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_slot),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_data (wr_entry)
    );

    rmt_exec #(
        .DEPTH_BITS (DEPTH_BITS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W),
        .SLOTS      (MUTEX_SLOTS)
    ) u_exec (
        .req       (a_req_reg),
        .count     (cnt_reg),
        .cur_owner (cur_entry[ENT_W-1:DEPTH_BITS]),
        .cur_depth (cur_entry[DEPTH_BITS-1:0]),
        .res       (res),
        .upd       (upd),
        .wr_slot   (wr_slot),
        .wr_owner  (wr_owner),
        .wr_depth  (wr_depth)
    );

    always_comb begin
        a_vld_next = a_vld_reg;
        if (accept) begin
            a_vld_next = 1'b1;
        end else if (a_adv) begin
            a_vld_next = 1'b0;
        end
        o_vld_next = o_vld_reg;
        if (a_adv) begin
            o_vld_next = 1'b1;
        end else if (m_tready) begin
            o_vld_next = 1'b0;
        end
        cnt_next = cnt_reg;
        if (a_adv && upd.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            o_vld_reg   <= 1'b0;
            cnt_reg     <= '0;
            byp_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            o_vld_reg <= o_vld_next;
            cnt_reg   <= cnt_next;
            if (accept) begin
                byp_vld_reg <= wr_en && (wr_slot == rd_slot);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_req_reg    <= s_req;
            byp_data_reg <= wr_entry;
        end
        if (a_adv) begin
            o_res_reg <= res;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {5'd0, o_res_reg};

endmodule

// ===== rtl/rmt_checker.sv =====
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks of the mutex table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import rmt_pkg::*;

    logic [2:0] st;
    logic       err_blank;

    assign st = m_tdata[2:0];
    // A refused id or a full table leaves every other field of the word at zero.
    assign err_blank = (m_tdata[18:3] == 16'd0);

    `RMT_ASSERT_NXT_ALL(a_reset_quiet, aclk, !aresetn, !m_tvalid)
    `RMT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata))
    `RMT_ASSERT_IMP(a_new_id_ok, aclk, aresetn, m_tvalid && (m_tdata[9:3] != 7'd0),
                    st == ST_OK)
    `RMT_ASSERT_IMP(a_refusal_blank, aclk, aresetn,
                    m_tvalid && ((st == ST_BAD_ID) || (st == ST_TABLE_FULL)), err_blank)

endmodule

bind recursive_mutex_table rmt_checker u_rmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
